// File: sv/etl_pkg.sv
// ----------------------------------------------------------------------------
// Expression token lexer package
// Token kinds, error codes, lexer modes and character helpers.
// ----------------------------------------------------------------------------
package etl_pkg;

  localparam int ValueWidthDefault = 32;

  localparam logic [4:0] TK_END     = 5'd0;
  localparam logic [4:0] TK_LPAREN  = 5'd1;
  localparam logic [4:0] TK_RPAREN  = 5'd2;
  localparam logic [4:0] TK_DOT     = 5'd3;
  localparam logic [4:0] TK_PLUS    = 5'd4;
  localparam logic [4:0] TK_MINUS   = 5'd5;
  localparam logic [4:0] TK_STAR    = 5'd6;
  localparam logic [4:0] TK_SLASH   = 5'd7;
  localparam logic [4:0] TK_PERCENT = 5'd8;
  localparam logic [4:0] TK_LAND    = 5'd9;
  localparam logic [4:0] TK_AMP     = 5'd10;
  localparam logic [4:0] TK_CARET   = 5'd11;
  localparam logic [4:0] TK_LOR     = 5'd12;
  localparam logic [4:0] TK_BAR     = 5'd13;
  localparam logic [4:0] TK_TILDE   = 5'd14;
  localparam logic [4:0] TK_EQ      = 5'd15;
  localparam logic [4:0] TK_NE      = 5'd16;
  localparam logic [4:0] TK_BANG    = 5'd17;
  localparam logic [4:0] TK_NUMBER  = 5'd18;
  localparam logic [4:0] TK_SHL     = 5'd19;
  localparam logic [4:0] TK_LE      = 5'd20;
  localparam logic [4:0] TK_LT      = 5'd21;
  localparam logic [4:0] TK_SHR     = 5'd22;
  localparam logic [4:0] TK_GE      = 5'd23;
  localparam logic [4:0] TK_GT      = 5'd24;
  localparam logic [4:0] TK_LCHAR   = 5'd25;
  localparam logic [4:0] TK_LEND    = 5'd26;
  localparam logic [4:0] TK_ERROR   = 5'd27;

  localparam logic [2:0] ERR_NONE     = 3'd0;
  localparam logic [2:0] ERR_NOHEX    = 3'd1;
  localparam logic [2:0] ERR_UNTERM   = 3'd2;
  localparam logic [2:0] ERR_EMPTY    = 3'd3;
  localparam logic [2:0] ERR_TOOLONG  = 3'd4;
  localparam logic [2:0] ERR_ESCAPE   = 3'd5;
  localparam logic [2:0] ERR_OCTAL    = 3'd6;
  localparam logic [2:0] ERR_UNRECOG  = 3'd7;

  typedef enum logic [17:0] {
    M_IDLE    = 18'h00001,
    M_AMP     = 18'h00002,
    M_BAR     = 18'h00004,
    M_EQ      = 18'h00008,
    M_BANG    = 18'h00010,
    M_LT      = 18'h00020,
    M_GT      = 18'h00040,
    M_DOLLAR  = 18'h00080,
    M_HEX     = 18'h00100,
    M_ZERO    = 18'h00200,
    M_OCT     = 18'h00400,
    M_DEC     = 18'h00800,
    M_QOPEN   = 18'h01000,
    M_QESC    = 18'h02000,
    M_QESCCH  = 18'h04000,
    M_QCH     = 18'h08000,
    M_LABEL   = 18'h10000,
    M_DISCARD = 18'h20000
  } mode_t;

  typedef struct packed {
    logic [4:0] kind;
    logic [7:0] ch;
    logic [2:0] err;
    logic       use_acc;
  } tok_t;

  function automatic logic is_hex(input logic [7:0] c);
    return (c >= "0" && c <= "9") || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
  endfunction

  function automatic logic [3:0] hex_val(input logic [7:0] c);
    logic [7:0] d;
    d = 8'd0;
    if (c >= "0" && c <= "9") d = c - 8'h30;
    else if (c >= "a" && c <= "f") d = c - 8'h57;
    else if (c >= "A" && c <= "F") d = c - 8'h37;
    return d[3:0];
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return c == " " || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  function automatic logic [7:0] upper(input logic [7:0] c);
    return (c >= "a" && c <= "z") ? c - 8'd32 : c;
  endfunction

  function automatic logic [8:0] escape_value(input logic [7:0] c);
    logic [8:0] r;
    case (c)
      8'h27:   r = {1'b1, 8'h27};
      8'h22:   r = {1'b1, 8'h22};
      8'h3F:   r = {1'b1, 8'h3F};
      8'h5C:   r = {1'b1, 8'h5C};
      "a":     r = {1'b1, 8'h07};
      "b":     r = {1'b1, 8'h08};
      "f":     r = {1'b1, 8'h0C};
      "n":     r = {1'b1, 8'h0A};
      "r":     r = {1'b1, 8'h0D};
      "t":     r = {1'b1, 8'h09};
      "v":     r = {1'b1, 8'h0B};
      default: r = 9'd0;
    endcase
    return r;
  endfunction

  function automatic tok_t mk(input logic [4:0] kind);
    tok_t t;
    t = '0;
    t.kind = kind;
    return t;
  endfunction

  function automatic tok_t mk_err(input logic [2:0] code);
    tok_t t;
    t = '0;
    t.kind = TK_ERROR;
    t.err = code;
    return t;
  endfunction

endpackage

// File: sv/expression_token_lexer_top.sv
// ----------------------------------------------------------------------------
// Expression token lexer
// Tokenizes a byte stream of integer expression text into operator, number,
// label and error tokens.
// ----------------------------------------------------------------------------
// Usage: the input channel (in_valid/in_stall) carries one byte or an end
// mark per beat. The output channel (out_valid/out_stall) carries tokens;
// a byte gives zero, one or two tokens, and "last" marks the final token
// of each input beat. Work for a byte is one pass of logic from the input
// beat to a two-entry result buffer, so a byte is taken every cycle while
// out_stall stays low, and its first token appears in the cycle after
// acceptance. A byte that gives two tokens holds the input while the
// second drains. When the receiver stalls, the result buffer fills and
// in_stall rises; no token is lost. Reset returns the lexer to idle with a
// zero value and clears the error latch and buffered tokens.
// ----------------------------------------------------------------------------
module expression_token_lexer_top
  import etl_pkg::*;
#(
  parameter int VALUE_WIDTH = ValueWidthDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  char_code,
  input  logic        end_of_input,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [4:0]  token_kind,
  output logic [31:0] number_value,
  output logic [7:0]  label_char,
  output logic [2:0]  error_code,
  output logic        last
);

  localparam int VW = VALUE_WIDTH;

  mode_t          mode, mode_next;
  logic [VW-1:0]  acc, acc_next;
  logic [7:0]     held, held_next;
  logic           err_lat, err_lat_next;

  tok_t           t0, t1;
  logic [1:0]     ntok;
  logic [VW-1:0]  val0, val1;

  // Two-entry result buffer.
  logic [1:0]     cnt;
  logic           rd;
  tok_t           b_tok [2];
  logic [31:0]    b_val [2];
  logic           b_last [2];

  logic           accept;
  logic [VW-1:0]  dec_mul;
  logic [7:0]     c;
  logic           redo;
  mode_t          m2;
  logic [VW-1:0]  a2;
  logic [8:0]     esc;

  assign c        = char_code;
  assign in_stall = (cnt != 2'd0) && !(cnt == 2'd1 && out_valid && !out_stall);
  assign accept   = in_valid && !in_stall;
  assign dec_mul  = (acc << 3) + (acc << 1);
  assign esc      = escape_value(held);

  always_comb begin
    mode_next = mode;
    acc_next  = acc;
    held_next = held;
    err_lat_next = err_lat;
    t0 = '0; t1 = '0; ntok = 2'd0;
    redo = 1'b0;
    m2 = M_IDLE;
    a2 = acc;
    if (end_of_input) begin
      case (mode)
        M_AMP:    begin t0 = mk(TK_AMP); ntok = 2'd1; end
        M_BAR:    begin t0 = mk(TK_BAR); ntok = 2'd1; end
        M_EQ:     begin t0 = mk(TK_EQ); ntok = 2'd1; end
        M_BANG:   begin t0 = mk(TK_BANG); ntok = 2'd1; end
        M_LT:     begin t0 = mk(TK_LT); ntok = 2'd1; end
        M_GT:     begin t0 = mk(TK_GT); ntok = 2'd1; end
        M_DOLLAR: begin t0 = mk_err(ERR_NOHEX); ntok = 2'd1; end
        M_HEX, M_ZERO, M_OCT, M_DEC: begin
          t0 = mk(TK_NUMBER); t0.use_acc = 1'b1; ntok = 2'd1;
        end
        M_QOPEN, M_QESC, M_QESCCH, M_QCH: begin
          t0 = mk_err(ERR_UNTERM); ntok = 2'd1;
        end
        M_LABEL:  begin t0 = mk(TK_LEND); ntok = 2'd1; end
        default:  ;
      endcase
      if (ntok == 2'd1) t1 = mk(TK_END);
      else t0 = mk(TK_END);
      ntok = ntok + 2'd1;
      mode_next = M_IDLE;
      acc_next = '0;
      err_lat_next = 1'b0;
    end else if (mode == M_DISCARD || err_lat) begin
      ntok = 2'd0;
    end else begin
      case (mode)
        M_IDLE: redo = 1'b1;
        M_AMP: begin
          if (c == "&") begin t0 = mk(TK_LAND); mode_next = M_IDLE; end
          else begin t0 = mk(TK_AMP); redo = 1'b1; end
          ntok = 2'd1;
        end
        M_BAR: begin
          if (c == "|") begin t0 = mk(TK_LOR); mode_next = M_IDLE; end
          else begin t0 = mk(TK_BAR); redo = 1'b1; end
          ntok = 2'd1;
        end
        M_EQ: begin
          t0 = mk(TK_EQ); ntok = 2'd1;
          if (c == "=") mode_next = M_IDLE;
          else redo = 1'b1;
        end
        M_BANG: begin
          if (c == "=") begin t0 = mk(TK_NE); mode_next = M_IDLE; end
          else begin t0 = mk(TK_BANG); redo = 1'b1; end
          ntok = 2'd1;
        end
        M_LT: begin
          if (c == "<") begin t0 = mk(TK_SHL); mode_next = M_IDLE; end
          else if (c == "=") begin t0 = mk(TK_LE); mode_next = M_IDLE; end
          else begin t0 = mk(TK_LT); redo = 1'b1; end
          ntok = 2'd1;
        end
        M_GT: begin
          if (c == ">") begin t0 = mk(TK_SHR); mode_next = M_IDLE; end
          else if (c == "=") begin t0 = mk(TK_GE); mode_next = M_IDLE; end
          else begin t0 = mk(TK_GT); redo = 1'b1; end
          ntok = 2'd1;
        end
        M_DOLLAR: begin
          if (is_hex(c)) begin
            acc_next = VW'(hex_val(c)); mode_next = M_HEX;
          end else begin
            t0 = mk_err(ERR_NOHEX); ntok = 2'd1;
            mode_next = M_DISCARD; err_lat_next = 1'b1;
          end
        end
        M_HEX: begin
          if (is_hex(c)) acc_next = (acc << 4) + VW'(hex_val(c));
          else begin
            t0 = mk(TK_NUMBER); t0.use_acc = 1'b1; ntok = 2'd1; redo = 1'b1;
          end
        end
        M_ZERO: begin
          if (c == "x" || c == "X") begin acc_next = '0; mode_next = M_HEX; end
          else if (is_digit(c)) begin
            if (c > "7") begin
              t0 = mk_err(ERR_OCTAL); ntok = 2'd1;
              mode_next = M_DISCARD; err_lat_next = 1'b1;
            end else begin
              acc_next = VW'(c[2:0]); mode_next = M_OCT;
            end
          end else begin
            t0 = mk(TK_NUMBER); t0.use_acc = 1'b1; ntok = 2'd1; redo = 1'b1;
          end
        end
        M_OCT: begin
          if (is_digit(c)) begin
            if (c > "7") begin
              t0 = mk_err(ERR_OCTAL); ntok = 2'd1;
              mode_next = M_DISCARD; err_lat_next = 1'b1;
            end else acc_next = (acc << 3) + VW'(c[2:0]);
          end else begin
            t0 = mk(TK_NUMBER); t0.use_acc = 1'b1; ntok = 2'd1; redo = 1'b1;
          end
        end
        M_DEC: begin
          if (is_digit(c)) acc_next = dec_mul + VW'(c[3:0]);
          else begin
            t0 = mk(TK_NUMBER); t0.use_acc = 1'b1; ntok = 2'd1; redo = 1'b1;
          end
        end
        M_QOPEN: begin
          if (c == 8'h27) begin
            t0 = mk_err(ERR_EMPTY); ntok = 2'd1;
            mode_next = M_DISCARD; err_lat_next = 1'b1;
          end else if (c == 8'h5C) mode_next = M_QESC;
          else begin acc_next = VW'(c); mode_next = M_QCH; end
        end
        M_QESC: begin held_next = c; mode_next = M_QESCCH; end
        M_QESCCH: begin
          if (c != 8'h27) begin
            t0 = mk_err(ERR_TOOLONG); ntok = 2'd1;
            mode_next = M_DISCARD; err_lat_next = 1'b1;
          end else if (!esc[8]) begin
            t0 = mk_err(ERR_ESCAPE); ntok = 2'd1;
            mode_next = M_DISCARD; err_lat_next = 1'b1;
          end else begin
            acc_next = VW'(esc[7:0]);
            t0 = mk(TK_NUMBER); t0.use_acc = 1'b1; ntok = 2'd1;
            mode_next = M_IDLE;
          end
        end
        M_QCH: begin
          if (c != 8'h27) begin
            t0 = mk_err(ERR_TOOLONG); ntok = 2'd1;
            mode_next = M_DISCARD; err_lat_next = 1'b1;
          end else begin
            t0 = mk(TK_NUMBER); t0.use_acc = 1'b1; ntok = 2'd1;
            mode_next = M_IDLE;
          end
        end
        M_LABEL: begin
          if (is_alpha(c) || is_digit(c) || c == "_") begin
            t0 = mk(TK_LCHAR); t0.ch = upper(c); ntok = 2'd1;
          end else begin
            t0 = mk(TK_LEND); ntok = 2'd1; redo = 1'b1;
          end
        end
        default: redo = 1'b1;
      endcase
      if (redo) begin
        tok_t ti;
        logic has;
        ti = '0; has = 1'b0; m2 = M_IDLE; a2 = acc_next;
        if (is_space(c)) begin
          has = 1'b0;
        end else begin
          has = 1'b1;
          case (c)
            "(": ti = mk(TK_LPAREN);
            ")": ti = mk(TK_RPAREN);
            ".": ti = mk(TK_DOT);
            "+": ti = mk(TK_PLUS);
            "-": ti = mk(TK_MINUS);
            "*": ti = mk(TK_STAR);
            "/": ti = mk(TK_SLASH);
            "%": ti = mk(TK_PERCENT);
            "^": ti = mk(TK_CARET);
            "~": ti = mk(TK_TILDE);
            "&": begin has = 1'b0; m2 = M_AMP; end
            "|": begin has = 1'b0; m2 = M_BAR; end
            "=": begin has = 1'b0; m2 = M_EQ; end
            "!": begin has = 1'b0; m2 = M_BANG; end
            "<": begin has = 1'b0; m2 = M_LT; end
            ">": begin has = 1'b0; m2 = M_GT; end
            "$": begin has = 1'b0; m2 = M_DOLLAR; a2 = '0; end
            8'h27: begin has = 1'b0; m2 = M_QOPEN; a2 = '0; end
            default: begin
              if (is_alpha(c) || c == "_") begin
                ti = mk(TK_LCHAR); ti.ch = upper(c); m2 = M_LABEL;
              end else if (c == "0") begin
                has = 1'b0; a2 = '0; m2 = M_ZERO;
              end else if (is_digit(c)) begin
                has = 1'b0; a2 = VW'(c[3:0]); m2 = M_DEC;
              end else begin
                ti = mk_err(ERR_UNRECOG); m2 = M_DISCARD;
                err_lat_next = 1'b1;
              end
            end
          endcase
        end
        mode_next = m2;
        acc_next = a2;
        if (has) begin
          if (ntok == 2'd0) t0 = ti;
          else t1 = ti;
          ntok = ntok + 2'd1;
        end
      end
    end
  end

  assign val0 = t0.use_acc ? (mode == M_QESCCH ? acc_next : acc) : '0;
  assign val1 = '0;

  assign rd = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= M_IDLE;
      acc <= '0;
      held <= 8'd0;
      err_lat <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (accept) begin
        mode <= mode_next;
        acc <= acc_next;
        held <= held_next;
        err_lat <= err_lat_next;
      end
      if (rd && cnt == 2'd2) begin
        b_tok[0] <= b_tok[1];
        b_val[0] <= b_val[1];
        b_last[0] <= b_last[1];
      end
      if (accept && ntok != 2'd0) begin
        b_tok[0] <= t0;
        b_val[0] <= 32'(val0);
        b_last[0] <= (ntok == 2'd1);
        b_tok[1] <= t1;
        b_val[1] <= 32'(val1);
        b_last[1] <= 1'b1;
        cnt <= ntok;
      end else if (rd) begin
        cnt <= cnt - 2'd1;
      end
    end
  end

  assign out_valid    = (cnt != 2'd0);
  assign token_kind   = b_tok[0].kind;
  assign number_value = b_val[0];
  assign label_char   = b_tok[0].ch;
  assign error_code   = b_tok[0].err;
  assign last         = b_last[0];

endmodule

// File: tb/tb_expression_token_lexer_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Expression token lexer testbench
// Sends expression text one byte per beat, predicts the token stream with an
// independent lexer model and compares every token beat field by field.
// ----------------------------------------------------------------------------
module tb_expression_token_lexer_top;
  import etl_pkg::*;

  typedef enum int {
    L_IDLE, L_AMP, L_BAR, L_EQ, L_BANG, L_LT, L_GT, L_DOLLAR, L_HEX, L_ZERO,
    L_OCT, L_DEC, L_QOPEN, L_QESC, L_QESCCH, L_QCH, L_LABEL, L_DISCARD
  } lex_mode_t;

  typedef struct packed {
    logic [4:0]  kind;
    logic [31:0] value;
    logic [7:0]  lchar;
    logic [2:0]  err;
    logic        fin;
  } token_t;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  char_code;
  logic        end_of_input;
  logic        out_valid;
  logic        out_stall;
  logic [4:0]  token_kind;
  logic [31:0] number_value;
  logic [7:0]  label_char;
  logic [2:0]  error_code;
  logic        last;

  token_t    expected_tokens[$];
  token_t    step_tokens[$];
  lex_mode_t mode;
  logic [31:0] acc;
  logic [7:0]  held;
  logic        err_latch;
  int          errors;
  int          tokens_seen;
  int          bytes_sent;
  int          hold_cycles;
  bit          long_hold_req;

  expression_token_lexer_top dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .char_code(char_code), .end_of_input(end_of_input), .out_valid(out_valid),
    .out_stall(out_stall), .token_kind(token_kind), .number_value(number_value),
    .label_char(label_char), .error_code(error_code), .last(last)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic bit hexdig(input logic [7:0] c, output logic [3:0] v);
    if (c >= "0" && c <= "9") begin
      v = 4'(c - 8'h30);
      return 1;
    end
    if (c >= "a" && c <= "f") begin
      v = 4'(c - 8'h57);
      return 1;
    end
    if (c >= "A" && c <= "F") begin
      v = 4'(c - 8'h37);
      return 1;
    end
    v = 4'd0;
    return 0;
  endfunction

  function automatic bit decdig(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit letter(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic void push_token(input logic [4:0] k, input logic [31:0] v,
                                     input logic [7:0] ch, input logic [2:0] e);
    token_t t;
    t = '{kind: k, value: v, lchar: ch, err: e, fin: 1'b0};
    step_tokens = {step_tokens, t};
  endfunction

  function automatic void raise_error(input logic [2:0] e);
    push_token(TK_ERROR, 32'd0, 8'd0, e);
    mode = L_DISCARD;
    err_latch = 1'b1;
  endfunction

  task automatic lex_from_idle(input logic [7:0] c);
    if (c == " " || (c >= 8'h09 && c <= 8'h0D)) return;
    case (c)
      "(": push_token(TK_LPAREN, 0, 0, ERR_NONE);
      ")": push_token(TK_RPAREN, 0, 0, ERR_NONE);
      ".": push_token(TK_DOT, 0, 0, ERR_NONE);
      "+": push_token(TK_PLUS, 0, 0, ERR_NONE);
      "-": push_token(TK_MINUS, 0, 0, ERR_NONE);
      "*": push_token(TK_STAR, 0, 0, ERR_NONE);
      "/": push_token(TK_SLASH, 0, 0, ERR_NONE);
      "%": push_token(TK_PERCENT, 0, 0, ERR_NONE);
      "^": push_token(TK_CARET, 0, 0, ERR_NONE);
      "~": push_token(TK_TILDE, 0, 0, ERR_NONE);
      "&": mode = L_AMP;
      "|": mode = L_BAR;
      "=": mode = L_EQ;
      "!": mode = L_BANG;
      "<": mode = L_LT;
      ">": mode = L_GT;
      "$": begin
        mode = L_DOLLAR;
        acc = 0;
      end
      8'h27: begin
        mode = L_QOPEN;
        acc = 0;
      end
      default: begin
        if (letter(c) || c == "_") begin
          push_token(TK_LCHAR, 0, (c >= "a" && c <= "z") ? c - 8'd32 : c, ERR_NONE);
          mode = L_LABEL;
        end else if (c == "0") begin
          acc = 0;
          mode = L_ZERO;
        end else if (decdig(c)) begin
          acc = 32'(c - 8'h30);
          mode = L_DEC;
        end else begin
          raise_error(ERR_UNRECOG);
        end
      end
    endcase
  endtask

  // Returns 1 when the byte must be lexed again from idle.
  function automatic bit lex_pending(input logic [7:0] c);
    logic [3:0] hv;
    logic [8:0] esc;
    bit num_end;
    num_end = 0;
    case (mode)
      L_AMP: begin
        mode = L_IDLE;
        push_token(c == "&" ? TK_LAND : TK_AMP, 0, 0, ERR_NONE);
        return c != "&";
      end
      L_BAR: begin
        mode = L_IDLE;
        push_token(c == "|" ? TK_LOR : TK_BAR, 0, 0, ERR_NONE);
        return c != "|";
      end
      L_EQ: begin
        mode = L_IDLE;
        push_token(TK_EQ, 0, 0, ERR_NONE);
        return c != "=";
      end
      L_BANG: begin
        mode = L_IDLE;
        push_token(c == "=" ? TK_NE : TK_BANG, 0, 0, ERR_NONE);
        return c != "=";
      end
      L_LT: begin
        mode = L_IDLE;
        push_token(c == "<" ? TK_SHL : c == "=" ? TK_LE : TK_LT, 0, 0, ERR_NONE);
        return c != "<" && c != "=";
      end
      L_GT: begin
        mode = L_IDLE;
        push_token(c == ">" ? TK_SHR : c == "=" ? TK_GE : TK_GT, 0, 0, ERR_NONE);
        return c != ">" && c != "=";
      end
      L_DOLLAR: begin
        if (!hexdig(c, hv)) raise_error(ERR_NOHEX);
        else begin
          acc = 32'(hv);
          mode = L_HEX;
        end
        return 0;
      end
      L_HEX: begin
        if (hexdig(c, hv)) begin
          acc = {acc[27:0], hv};
          return 0;
        end
        num_end = 1;
      end
      L_ZERO: begin
        if (c == "x" || c == "X") begin
          acc = 0;
          mode = L_HEX;
          return 0;
        end
        if (decdig(c)) begin
          if (c > "7") raise_error(ERR_OCTAL);
          else begin
            acc = 32'(c - 8'h30);
            mode = L_OCT;
          end
          return 0;
        end
        num_end = 1;
      end
      L_OCT: begin
        if (decdig(c)) begin
          if (c > "7") raise_error(ERR_OCTAL);
          else acc = {acc[28:0], 3'b000} + 32'(c - 8'h30);
          return 0;
        end
        num_end = 1;
      end
      L_DEC: begin
        if (decdig(c)) begin
          acc = acc * 32'd10 + 32'(c - 8'h30);
          return 0;
        end
        num_end = 1;
      end
      L_QOPEN: begin
        if (c == 8'h27) raise_error(ERR_EMPTY);
        else if (c == 8'h5C) mode = L_QESC;
        else begin
          acc = 32'(c);
          mode = L_QCH;
        end
        return 0;
      end
      L_QESC: begin
        held = c;
        mode = L_QESCCH;
        return 0;
      end
      L_QESCCH: begin
        case (held)
          8'h27: esc = 9'h127;
          8'h22: esc = 9'h122;
          8'h3F: esc = 9'h13F;
          8'h5C: esc = 9'h15C;
          "a":   esc = 9'h107;
          "b":   esc = 9'h108;
          "f":   esc = 9'h10C;
          "n":   esc = 9'h10A;
          "r":   esc = 9'h10D;
          "t":   esc = 9'h109;
          "v":   esc = 9'h10B;
          default: esc = 9'h000;
        endcase
        if (c != 8'h27) raise_error(ERR_TOOLONG);
        else if (!esc[8]) raise_error(ERR_ESCAPE);
        else begin
          push_token(TK_NUMBER, 32'(esc[7:0]), 0, ERR_NONE);
          mode = L_IDLE;
        end
        return 0;
      end
      L_QCH: begin
        if (c != 8'h27) raise_error(ERR_TOOLONG);
        else begin
          push_token(TK_NUMBER, acc, 0, ERR_NONE);
          mode = L_IDLE;
        end
        return 0;
      end
      L_LABEL: begin
        if (letter(c) || decdig(c) || c == "_") begin
          push_token(TK_LCHAR, 0, (c >= "a" && c <= "z") ? c - 8'd32 : c, ERR_NONE);
          return 0;
        end
        push_token(TK_LEND, 0, 0, ERR_NONE);
        mode = L_IDLE;
        return 1;
      end
      default: begin
        mode = L_IDLE;
        return 1;
      end
    endcase
    push_token(TK_NUMBER, acc, 0, ERR_NONE);
    mode = L_IDLE;
    return 1;
  endfunction

  task automatic predict_tokens(input logic [7:0] c, input logic eoi);
    step_tokens.delete();
    if (eoi) begin
      case (mode)
        L_AMP:  push_token(TK_AMP, 0, 0, ERR_NONE);
        L_BAR:  push_token(TK_BAR, 0, 0, ERR_NONE);
        L_EQ:   push_token(TK_EQ, 0, 0, ERR_NONE);
        L_BANG: push_token(TK_BANG, 0, 0, ERR_NONE);
        L_LT:   push_token(TK_LT, 0, 0, ERR_NONE);
        L_GT:   push_token(TK_GT, 0, 0, ERR_NONE);
        L_DOLLAR: raise_error(ERR_NOHEX);
        L_HEX, L_ZERO, L_OCT, L_DEC: push_token(TK_NUMBER, acc, 0, ERR_NONE);
        L_QOPEN, L_QESC, L_QESCCH, L_QCH: raise_error(ERR_UNTERM);
        L_LABEL: push_token(TK_LEND, 0, 0, ERR_NONE);
        default: ;
      endcase
      push_token(TK_END, 0, 0, ERR_NONE);
      mode = L_IDLE;
      acc = 0;
      err_latch = 1'b0;
    end else if (mode == L_DISCARD || err_latch) begin
    end else if (mode == L_IDLE) begin
      lex_from_idle(c);
    end else if (lex_pending(c)) begin
      lex_from_idle(c);
    end
    if (step_tokens.size() > 0) step_tokens[step_tokens.size() - 1].fin = 1'b1;
    foreach (step_tokens[i]) expected_tokens = {expected_tokens, step_tokens[i]};
  endtask

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  task automatic send_byte(input logic [7:0] c, input logic eoi);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_valid <= 1'b0;
      char_code <= 8'($urandom);
      end_of_input <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1'b1;
    char_code <= c;
    end_of_input <= eoi;
    predict_tokens(c, eoi);
    @(posedge clk);
    while (in_stall) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_text(input string s, input bit finish);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], 1'b0);
    if (finish) send_byte(8'($urandom), 1'b1);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    end_of_input <= 1'b0;
    while (expected_tokens.size() > 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic test_operators();
    send_text("( ) . + - * / % ^ ~ && & || | == = != ! << <= < >> >= >", 1);
    send_text("&", 1);
    send_text("<", 1);
    send_text("a&&b|c!d=e>f", 1);
  endtask

  task automatic test_numbers();
    send_text("$FFFFFFFF $123456789 0x 0xAbCdEf12 0X0 0777 0 4294967295 99999999999", 1);
    send_text("$", 1);
    send_text("$g", 1);
    send_text("08", 1);
    send_text("0179", 1);
    send_text("12ab", 1);
  endtask

  task automatic test_char_constants();
    send_text("'a' '\\n' '\\'' '\\\\' '\\?' '\"'", 1);
    send_byte(8'h27, 0);
    send_byte(8'hFF, 0);
    send_byte(8'h27, 0);
    send_byte(0, 1);
    send_text("''", 1);
    send_text("'ab'", 1);
    send_text("'\\q'", 1);
    send_text("'\\qx", 1);
    send_text("'\\n", 1);
    send_text("'", 1);
  endtask

  task automatic test_labels_and_errors();
    send_text("_abc_Z9 xyz", 1);
    send_text("foo @ bar + 3", 1);
    send_byte(8'h80, 0);
    send_byte(8'h00, 1);
    send_text("\t\n\v\f\r 7", 1);
  endtask

  function automatic string random_token();
    string pool[$];
    string s;
    string hex_chars;
    string oct_chars;
    string dec_chars;
    string esc_chars;
    string name_chars;
    int n;
    int k;
    hex_chars = "0123456789abcdefABCDEF";
    oct_chars = "01234567";
    dec_chars = "0123456789";
    esc_chars = "'\"?\\abfnrtv";
    name_chars = "abcxyzABCXYZ_09";
    pool = '{"(", ")", ".", "+", "-", "*", "/", "%", "^", "~", "&&", "&", "||", "|",
             "==", "=", "!=", "!", "<<", "<=", "<", ">>", ">=", ">", " ", "\t"};
    case ($urandom_range(0, 9))
      0, 1, 2: return pool[$urandom_range(0, pool.size() - 1)];
      3: begin
        s = "$";
        n = $urandom_range(1, 10);
        repeat (n) begin
          k = $urandom_range(0, 21);
          s = {s, hex_chars.substr(k, k)};
        end
        return s;
      end
      4: begin
        if ($urandom_range(0, 1)) s = "0x";
        else s = "0";
        n = $urandom_range(0, 12);
        repeat (n) begin
          k = $urandom_range(0, 7);
          s = {s, oct_chars.substr(k, k)};
        end
        return s;
      end
      5: begin
        s = "";
        n = $urandom_range(1, 12);
        repeat (n) begin
          k = $urandom_range(0, 9);
          s = {s, dec_chars.substr(k, k)};
        end
        if (s[0] == "0") s[0] = "5";
        return s;
      end
      6: begin
        s = "'";
        if ($urandom_range(0, 1)) begin
          k = $urandom_range(0, 10);
          s = {s, "\\", esc_chars.substr(k, k)};
        end else begin
          s = {s, " "};
          s[1] = 8'($urandom_range(1, 255));
          if (s[1] == 8'h27 || s[1] == 8'h5C) s[1] = "q";
        end
        return {s, "'"};
      end
      7, 8: begin
        s = "";
        n = $urandom_range(1, 6);
        repeat (n) begin
          k = $urandom_range(0, 14);
          s = {s, name_chars.substr(k, k)};
        end
        if (decdig(s[0])) s[0] = "k";
        return s;
      end
      default: begin
        s = " ";
        s[0] = 8'($urandom_range(1, 255));
        return s;
      end
    endcase
  endfunction

  task automatic test_random_expressions(input int budget);
    string s;
    int start;
    start = bytes_sent;
    while (bytes_sent - start < budget) begin
      s = "";
      repeat ($urandom_range(1, 8)) s = {s, random_token()};
      send_text(s, $urandom_range(0, 3) != 0);
    end
    send_byte(0, 1);
  endtask

  task automatic test_backpressure();
    long_hold_req = 1;
    send_text("a+b==$ff<<3 'x' 0777 || q1", 1);
    send_text("foo&&bar", 1);
    drain();
  endtask

  initial begin
    hold_cycles = 0;
    forever begin
      @(posedge clk);
      if (long_hold_req) begin
        long_hold_req = 0;
        out_stall <= 1'b1;
        for (hold_cycles = 0; hold_cycles < 60; hold_cycles++) @(posedge clk);
        out_stall <= 1'b0;
      end else if (out_stall) begin
        out_stall <= ($urandom_range(0, 99) < 60);
      end else begin
        out_stall <= ($urandom_range(0, 99) < 20);
      end
    end
  end

  always @(posedge clk) begin
    token_t want;
    if (!rst && out_valid && !out_stall) begin
      tokens_seen++;
      if (expected_tokens.size() == 0) begin
        $error("unexpected token kind %0d", token_kind);
        errors++;
      end else begin
        want = expected_tokens.pop_front();
        if (token_kind !== want.kind) begin
          $error("token_kind expected %0d actual %0d", want.kind, token_kind);
          errors++;
        end
        if (number_value !== want.value) begin
          $error("number_value expected %0h actual %0h", want.value, number_value);
          errors++;
        end
        if (label_char !== want.lchar) begin
          $error("label_char expected %0h actual %0h", want.lchar, label_char);
          errors++;
        end
        if (error_code !== want.err) begin
          $error("error_code expected %0d actual %0d", want.err, error_code);
          errors++;
        end
        if (last !== want.fin) begin
          $error("last expected %0b actual %0b", want.fin, last);
          errors++;
        end
      end
    end
  end

  initial begin
    #5000000;
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    rst <= 1'b1;
    in_valid <= 1'b0;
    char_code <= 8'h00;
    end_of_input <= 1'b0;
    out_stall <= 1'b0;
    errors = 0;
    tokens_seen = 0;
    bytes_sent = 0;
    long_hold_req = 0;
    mode = L_IDLE;
    acc = 0;
    held = 0;
    err_latch = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_operators();
    test_numbers();
    test_char_constants();
    test_labels_and_errors();
    drain();
    test_random_expressions(780);
    test_backpressure();
    test_random_expressions(780);
    drain();
    repeat (10) @(posedge clk);
    if (expected_tokens.size() != 0) begin
      $error("%0d expected tokens never arrived", expected_tokens.size());
      errors++;
    end
    $display("Sent %0d bytes of expression text and checked %0d token beats,",
             bytes_sent, tokens_seen);
    $display("covering operators, numbers, character constants, labels and errors.");
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// File: expression_token_lexer_top.f
sv/etl_pkg.sv
sv/expression_token_lexer_top.sv
tb/tb_expression_token_lexer_top.sv
